/* rtl/core/sira_pkg.sv */
// shared types and constants for the saturating integer reduce unit
`timescale 1ns / 1ps

package sira_pkg;

  // operation codes carried by the mode field
  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_AVG = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_MUL_FIN,
    ST_DIV,
    ST_DIV_FIN,
    ST_AVG_LOAD,
    ST_AVG_DIV,
    ST_EMIT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic mul_step;
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic avg_load;
    logic emit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic last;
    logic avg_last;
  } sts_t;

endpackage

/* rtl/core/sira_ctrl.sv */
// controller state machine for the saturating integer reduce unit
`timescale 1ns / 1ps

module sira_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  sira_pkg::sts_t  sts,
  output sira_pkg::cmd_t  cmd
);

  localparam int CW = $clog2(DATA_WIDTH);
  localparam logic [CW-1:0] STEP_LAST = CW'(DATA_WIDTH - 1);

  sira_pkg::state_t state_r, state_nxt, post_state;
  logic [CW-1:0]    step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             iterating;
  logic             step_done;

  assign out_free  = !out_valid_r || !out_stall;
  assign step_done = (step_r == STEP_LAST);
  assign iterating = (state_r == sira_pkg::ST_MUL) || (state_r == sira_pkg::ST_DIV) ||
                     (state_r == sira_pkg::ST_AVG_DIV);

  // where to go once the item's operation has been applied
  always_comb begin
    if (!sts.last) begin
      post_state = sira_pkg::ST_IDLE;
    end else if (sts.avg_last) begin
      post_state = sira_pkg::ST_AVG_LOAD;
    end else begin
      post_state = sira_pkg::ST_EMIT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sira_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sira_pkg::ST_PREP;
      end
      sira_pkg::ST_PREP: begin
        if (sts.need_mul) begin
          state_nxt = sira_pkg::ST_MUL;
        end else if (sts.need_div) begin
          state_nxt = sira_pkg::ST_DIV;
        end else begin
          state_nxt = post_state;
        end
      end
      sira_pkg::ST_MUL: begin
        if (step_done) state_nxt = sira_pkg::ST_MUL_FIN;
      end
      sira_pkg::ST_MUL_FIN:  state_nxt = post_state;
      sira_pkg::ST_DIV: begin
        if (step_done) state_nxt = sira_pkg::ST_DIV_FIN;
      end
      sira_pkg::ST_DIV_FIN:  state_nxt = post_state;
      sira_pkg::ST_AVG_LOAD: state_nxt = sira_pkg::ST_AVG_DIV;
      sira_pkg::ST_AVG_DIV: begin
        if (step_done) state_nxt = sira_pkg::ST_EMIT;
      end
      sira_pkg::ST_EMIT: begin
        if (out_free) state_nxt = sira_pkg::ST_IDLE;
      end
      default: state_nxt = sira_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      sira_pkg::ST_IDLE:     cmd.load     = in_valid;
      sira_pkg::ST_PREP:     cmd.prep     = 1'b1;
      sira_pkg::ST_MUL:      cmd.mul_step = 1'b1;
      sira_pkg::ST_MUL_FIN:  cmd.mul_fin  = 1'b1;
      sira_pkg::ST_DIV:      cmd.div_step = 1'b1;
      sira_pkg::ST_DIV_FIN:  cmd.div_fin  = 1'b1;
      sira_pkg::ST_AVG_LOAD: cmd.avg_load = 1'b1;
      sira_pkg::ST_AVG_DIV:  cmd.div_step = 1'b1;
      sira_pkg::ST_EMIT:     cmd.emit     = out_free;
      default:               cmd          = '0;
    endcase
  end

  assign step_nxt = iterating ? step_r + CW'(1) : '0;

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sira_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != sira_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/sira_dp.sv */
// datapath: run state, shift-add multiplier, restoring divider, result register
`timescale 1ns / 1ps

module sira_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_operand,
  input  logic               in_first_item,
  input  logic               in_last_item,
  input  sira_pkg::cmd_t     cmd,
  output sira_pkg::sts_t     sts,
  output logic signed [31:0] out_result,
  output logic               out_saturated,
  output logic               out_divide_by_zero
);

  localparam int W  = DATA_WIDTH;
  localparam int DW = (W > 32) ? W : 32;
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ONES = {W{1'b1}};
  localparam logic [W-1:0] ONE  = W'(1);

  logic chk_r;

  // latched item
  logic [2:0]   mode_r;
  logic [W-1:0] op_r;
  logic         first_r, last_r;

  // run state
  logic [W-1:0] acc_r, acc_nxt;
  logic [31:0]  cnt_r, cnt_nxt;
  logic         stop_r, stop_nxt;
  logic         sat_r, sat_nxt;
  logic         dz_r, dz_nxt;

  // iterative units
  logic [2*W-1:0] prod_r, prod_nxt;
  logic [W-1:0]   mcand_r, mcand_nxt;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]  dvs_r, dvs_nxt;
  logic           neg_r, neg_nxt;

  // output register
  logic signed [31:0] res_r;
  logic               osat_r, odz_r;

  logic         start, active;
  logic [W-1:0] a_init, a_eff, a_mag, b_mag, acc_mag;
  logic [W-1:0] sum, dif, sat_val;
  logic         ov_add, ov_sub;
  logic         div_zero, div_minus;
  logic [W:0]   msum;
  logic [DW:0]  shifted, diff;
  logic         ge;
  logic [W-1:0] lim, plow, quo_signed, res_w;
  logic         mul_ovf;

  assign start  = first_r || (cnt_r == '0);
  assign active = start || !stop_r;

  always_comb begin
    unique case (mode_r)
      sira_pkg::MODE_MUL: a_init = ONE;
      sira_pkg::MODE_DIV: a_init = op_r;
      default:            a_init = '0;
    endcase
  end

  assign a_eff   = start ? a_init : acc_r;
  assign a_mag   = a_eff[W-1] ? -a_eff : a_eff;
  assign b_mag   = op_r[W-1] ? -op_r : op_r;
  assign acc_mag = acc_r[W-1] ? -acc_r : acc_r;
  assign sum     = a_eff + op_r;
  assign dif     = a_eff - op_r;
  assign ov_add  = (a_eff[W-1] == op_r[W-1]) && (sum[W-1] != a_eff[W-1]);
  assign ov_sub  = (a_eff[W-1] != op_r[W-1]) && (dif[W-1] != a_eff[W-1]);
  assign sat_val = a_eff[W-1] ? SMIN : SMAX;

  assign div_zero  = (op_r == '0);
  assign div_minus = (a_eff == SMIN) && (op_r == ONES);

  assign sts.need_mul = active && (mode_r == sira_pkg::MODE_MUL);
  assign sts.need_div = active && !start && (mode_r == sira_pkg::MODE_DIV) &&
                        !div_zero && !div_minus;
  assign sts.last     = last_r;
  assign sts.avg_last = last_r && (mode_r == sira_pkg::MODE_AVG);

  // one bit of the shift-add multiply
  assign msum = {1'b0, prod_r[2*W-1:W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);

  // one bit of the restoring divide; the remainder stays below the divisor
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = !diff[DW];

  assign lim        = neg_r ? SMIN : SMAX;
  assign plow       = prod_r[W-1:0];
  assign mul_ovf    = prod_r > {{W{1'b0}}, lim};
  assign quo_signed = neg_r ? -quo_r : quo_r;
  assign res_w      = sts.avg_last ? quo_signed : acc_r;

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    sat_nxt  = sat_r;
    dz_nxt   = dz_r;
    if (cmd.prep) begin
      if (start) begin
        cnt_nxt  = 32'd1;
        stop_nxt = 1'b0;
        sat_nxt  = 1'b0;
        dz_nxt   = 1'b0;
      end else if (!stop_r && (cnt_r != '1)) begin
        cnt_nxt = cnt_r + 32'd1;
      end
      acc_nxt = a_eff;
      if (active) begin
        unique case (mode_r)
          sira_pkg::MODE_ADD: begin
            if (chk_r && ov_add) begin
              acc_nxt  = sat_val;
              sat_nxt  = 1'b1;
              stop_nxt = 1'b1;
            end else begin
              acc_nxt = sum;
            end
          end
          sira_pkg::MODE_SUB: begin
            if (chk_r && ov_sub) begin
              acc_nxt  = sat_val;
              sat_nxt  = 1'b1;
              stop_nxt = 1'b1;
            end else begin
              acc_nxt = dif;
            end
          end
          sira_pkg::MODE_AVG: acc_nxt = sum;
          sira_pkg::MODE_DIV: begin
            // the starting item only loads the dividend
            if (!start) begin
              if (div_zero) begin
                acc_nxt  = (a_eff == '0) ? a_eff : sat_val;
                dz_nxt   = 1'b1;
                stop_nxt = 1'b1;
              end else if (div_minus) begin
                acc_nxt  = SMAX;
                sat_nxt  = 1'b1;
                stop_nxt = 1'b1;
              end
            end
          end
          default: acc_nxt = a_eff;
        endcase
      end
    end else if (cmd.mul_fin) begin
      if (chk_r && mul_ovf) begin
        acc_nxt  = lim;
        sat_nxt  = 1'b1;
        stop_nxt = 1'b1;
      end else begin
        acc_nxt = neg_r ? -plow : plow;
      end
    end else if (cmd.div_fin) begin
      acc_nxt = quo_signed;
    end else if (cmd.emit) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      stop_nxt = 1'b0;
      sat_nxt  = 1'b0;
      dz_nxt   = 1'b0;
    end
  end

  always_comb begin
    prod_nxt  = prod_r;
    mcand_nxt = mcand_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    neg_nxt   = neg_r;
    if (cmd.prep) begin
      mcand_nxt = a_mag;
      prod_nxt  = {{W{1'b0}}, b_mag};
      rem_nxt   = '0;
      quo_nxt   = a_mag;
      dvs_nxt   = DW'(b_mag);
      neg_nxt   = a_eff[W-1] ^ op_r[W-1];
    end else if (cmd.avg_load) begin
      rem_nxt = '0;
      quo_nxt = acc_mag;
      dvs_nxt = DW'(cnt_r);
      neg_nxt = acc_r[W-1];
    end else if (cmd.mul_step) begin
      prod_nxt = {msum, prod_r[W-1:1]};
    end else if (cmd.div_step) begin
      rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r  <= 1'b1;
      acc_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
      sat_r  <= 1'b0;
      dz_r   <= 1'b0;
    end else begin
      if (cfg_we) chk_r <= cfg_wdata;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
      sat_r  <= sat_nxt;
      dz_r   <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      op_r    <= W'(in_operand);
      first_r <= in_first_item;
      last_r  <= in_last_item;
    end
    prod_r  <= prod_nxt;
    mcand_r <= mcand_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    neg_r   <= neg_nxt;
    if (cmd.emit) begin
      res_r  <= 32'($signed(res_w));
      osat_r <= sat_r;
      odz_r  <= dz_r;
    end
  end

  assign out_result         = res_r;
  assign out_saturated      = osat_r;
  assign out_divide_by_zero = odz_r;

endmodule

/* rtl/core/saturating_integer_reduce_alu_unit.sv */
// top level of the saturating integer reduce unit
`timescale 1ns / 1ps

// Folds a run of signed operands into one result under the item's mode (sum,
// negated sum, product, left-to-right quotient, truncating average), with
// optional saturation that ends the run. One item is taken at a time: after
// the transfer, add, subtract, average and the divide cases settled without
// dividing pass through the prep state only; multiply and divide then run
// the one-bit-per-cycle shift-add or restoring unit and a finish state. A
// last item then loads the result register, and that step waits while an
// earlier result is still stalled; a last average item also runs the
// divider once more. The next item is taken while a result waits.
module saturating_integer_reduce_alu_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_operand,
  input  logic               in_first_item,
  input  logic               in_last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result,
  output logic               out_saturated,
  output logic               out_divide_by_zero
);

  sira_pkg::cmd_t cmd;
  sira_pkg::sts_t sts;

  sira_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sira_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_mode),
    .in_operand         (in_operand),
    .in_first_item      (in_first_item),
    .in_last_item       (in_last_item),
    .cmd                (cmd),
    .sts                (sts),
    .out_result         (out_result),
    .out_saturated      (out_saturated),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

/* rtl/core/sira_chk.sv */
// port-level checker for the saturating integer reduce unit, with its bind
`timescale 1ns / 1ps

module sira_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result,
  input logic        out_saturated,
  input logic        out_divide_by_zero
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result) &&
    $stable(out_saturated) && $stable(out_divide_by_zero))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // a new result is loaded only while an item is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // a run stops on the first limit or zero divisor, never both
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_saturated && out_divide_by_zero))
    else $error("saturated and divide by zero both set");

endmodule

bind saturating_integer_reduce_alu_unit sira_chk u_sira_chk (.*);
